### hdl/lnorm_pkg.sv
// lnorm_pkg: shared types and constants for the layer normalization block
// command and status structs between controller and datapath, fixed widths
// no dependencies
`default_nettype none
package lnorm_pkg;

  localparam int unsigned DATA_W  = 16;
  localparam int unsigned SUM_W   = 24;
  localparam int unsigned NUM_W   = 26;
  localparam int unsigned N_W     = 7;
  localparam int unsigned DSQ_W   = 32;
  localparam int unsigned SQ_W    = 38;
  localparam int unsigned DIVN_W  = 57;
  localparam int unsigned DIVD_W  = 33;
  localparam int unsigned DCNT_W  = 6;
  localparam int unsigned RAD_W   = 58;
  localparam int unsigned ROOT_W  = 29;
  localparam int unsigned SREM_W  = 31;
  localparam int unsigned SCNT_W  = 5;
  localparam int unsigned MEAN_W  = 17;
  localparam int unsigned GD_W    = 33;
  localparam int unsigned P_W     = 63;
  localparam int unsigned Q_FRAC  = 28;

  localparam logic [ROOT_W-1:0] INV_CAP   = ROOT_W'(1) << 28;
  localparam logic [DATA_W-1:0] EPS_RESET = 16'd168;

  typedef enum logic [1:0] {
    DIV_MEAN = 2'd0,
    DIV_VAR  = 2'd1,
    DIV_INV  = 2'd2
  } div_sel_e;

  typedef enum logic [15:0] {
    ST_IDLE     = 16'b0000_0000_0000_0001,
    ST_MEAN_ST  = 16'b0000_0000_0000_0010,
    ST_MEAN_RUN = 16'b0000_0000_0000_0100,
    ST_VAR_RD   = 16'b0000_0000_0000_1000,
    ST_VAR_MUL  = 16'b0000_0000_0001_0000,
    ST_VAR_ACC  = 16'b0000_0000_0010_0000,
    ST_VDIV_ST  = 16'b0000_0000_0100_0000,
    ST_VDIV_RUN = 16'b0000_0000_1000_0000,
    ST_IDIV_ST  = 16'b0000_0001_0000_0000,
    ST_IDIV_RUN = 16'b0000_0010_0000_0000,
    ST_SQRT_ST  = 16'b0000_0100_0000_0000,
    ST_SQRT_RUN = 16'b0000_1000_0000_0000,
    ST_EMIT_RD  = 16'b0001_0000_0000_0000,
    ST_EMIT_M1  = 16'b0010_0000_0000_0000,
    ST_EMIT_M2  = 16'b0100_0000_0000_0000,
    ST_EMIT_OUT = 16'b1000_0000_0000_0000
  } state_e;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_e div_sel;
    logic     mean_take;
    logic     sq_clr;
    logic     rd_en;
    logic     sq_mul;
    logic     sq_acc;
    logic     addr_clr;
    logic     addr_inc;
    logic     var_take;
    logic     sqrt_start;
    logic     sqrt_take;
    logic     inv_cap;
    logic     m1;
    logic     m2;
    logic     out_load;
    logic     vec_clr;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic addr_last;
    logic vq_zero;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

### hdl/lnorm_if.sv
// lnorm_in_if, lnorm_out_if: valid/ready channels for items and results
// depends on nothing
`default_nettype none
interface lnorm_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic signed [15:0] gain;
  logic signed [15:0] offset;
  logic               last_in;
  modport source (output valid, sample, gain, offset, last_in, input ready);
  modport sink (input valid, sample, gain, offset, last_in, output ready);
endinterface

interface lnorm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] normalized;
  logic               last_out;
  logic               overflow;
  modport source (output valid, normalized, last_out, overflow, input ready);
  modport sink (input valid, normalized, last_out, overflow, output ready);
endinterface
`default_nettype wire

### hdl/lnorm_div.sv
// lnorm_div: shared restoring divider, one quotient bit per cycle
// depends on lnorm_pkg
`default_nettype none
module lnorm_div (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic [lnorm_pkg::DIVN_W-1:0]     dividend_i,
  input  wire logic [lnorm_pkg::DIVD_W-1:0]     divisor_i,
  output logic                                  done_o,
  output logic [lnorm_pkg::DIVN_W-1:0]          quot_o,
  output logic [lnorm_pkg::DIVD_W-1:0]          rem_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [lnorm_pkg::DCNT_W-1:0]  cnt_q;
  logic [lnorm_pkg::DIVN_W-1:0]  quot_q;
  logic [lnorm_pkg::DIVD_W-1:0]  rem_q;
  logic [lnorm_pkg::DIVD_W-1:0]  dvs_q;
  logic [lnorm_pkg::DIVD_W:0]    rem_sh;
  logic                          ge;
  logic [lnorm_pkg::DIVD_W:0]    rem_sub;

  assign rem_sh  = {rem_q, quot_q[lnorm_pkg::DIVN_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == lnorm_pkg::DCNT_W'(lnorm_pkg::DIVN_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[lnorm_pkg::DIVN_W-2:0], ge};
      rem_q  <= ge ? rem_sub[lnorm_pkg::DIVD_W-1:0] : rem_sh[lnorm_pkg::DIVD_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

### hdl/lnorm_isqrt.sv
// lnorm_isqrt: digit-by-digit integer square root, one root bit per cycle
// depends on lnorm_pkg
`default_nettype none
module lnorm_isqrt (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [lnorm_pkg::DIVN_W-1:0]    rad_i,
  output logic                                 done_o,
  output logic [lnorm_pkg::ROOT_W-1:0]         root_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [lnorm_pkg::SCNT_W-1:0]  cnt_q;
  logic [lnorm_pkg::RAD_W-1:0]   rad_q;
  logic [lnorm_pkg::SREM_W-1:0]  rem_q;
  logic [lnorm_pkg::ROOT_W-1:0]  root_q;
  logic [lnorm_pkg::SREM_W+1:0]  rem_sh;
  logic [lnorm_pkg::SREM_W+1:0]  trial;
  logic                          ge;
  logic [lnorm_pkg::SREM_W+1:0]  rem_sub;

  assign rem_sh  = {rem_q, rad_q[lnorm_pkg::RAD_W-1 -: 2]};
  assign trial   = (lnorm_pkg::SREM_W+2)'({root_q, 2'b01});
  assign ge      = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == lnorm_pkg::SCNT_W'(lnorm_pkg::ROOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= {1'b0, rad_i};
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[lnorm_pkg::RAD_W-3:0], 2'b00};
      rem_q  <= ge ? rem_sub[lnorm_pkg::SREM_W-1:0] : rem_sh[lnorm_pkg::SREM_W-1:0];
      root_q <= {root_q[lnorm_pkg::ROOT_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule
`default_nettype wire

### hdl/lnorm_dp.sv
// lnorm_dp: element store, statistics, emit arithmetic and result register
// depends on lnorm_pkg, lnorm_div, lnorm_isqrt
`default_nettype none
module lnorm_dp #(
  parameter int unsigned MAX_LEN = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire lnorm_pkg::cmd_t     cmd_i,
  output lnorm_pkg::sts_t          sts_o,
  input  wire logic                cfg_we_i,
  input  wire logic [15:0]         cfg_wdata_i,
  input  wire logic signed [15:0]  sample_i,
  input  wire logic signed [15:0]  gain_i,
  input  wire logic signed [15:0]  offset_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic signed [15:0]       normalized_o,
  output logic                     last_out_o,
  output logic                     overflow_o
);

  localparam int unsigned CW = $clog2(MAX_LEN + 1);
  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic [15:0]                      eps_q;
  logic [CW-1:0]                    count_q;
  logic signed [lnorm_pkg::SUM_W-1:0] sum_q;
  logic                             ovf_q;
  logic [47:0]                      mem [MAX_LEN];
  logic [47:0]                      rd_q;
  logic [AW-1:0]                    addr_q;
  logic signed [lnorm_pkg::MEAN_W-1:0] mean_q;
  logic [lnorm_pkg::DSQ_W-1:0]      dsq_q;
  logic [lnorm_pkg::SQ_W-1:0]       sq_q;
  logic [lnorm_pkg::DIVD_W-1:0]     vq_q;
  logic [lnorm_pkg::ROOT_W-1:0]     inv_q;
  logic signed [lnorm_pkg::GD_W-1:0] gd_q;
  logic signed [15:0]               ofs_q;
  logic signed [lnorm_pkg::P_W-1:0] p_q;
  logic                             out_valid_q;
  logic signed [15:0]               norm_q;
  logic                             last_q;
  logic                             oflag_q;

  logic                             full;
  logic [lnorm_pkg::N_W-1:0]        n7;
  logic signed [lnorm_pkg::NUM_W-1:0] num;
  logic                             num_neg;
  logic [lnorm_pkg::NUM_W-1:0]      num_abs;
  logic [lnorm_pkg::DIVN_W-1:0]     div_dividend;
  logic [lnorm_pkg::DIVD_W-1:0]     div_divisor;
  logic                             div_done;
  logic [lnorm_pkg::DIVN_W-1:0]     div_quot;
  logic [lnorm_pkg::DIVD_W-1:0]     div_rem;
  logic                             sqrt_done;
  logic [lnorm_pkg::ROOT_W-1:0]     sqrt_root;
  logic [lnorm_pkg::MEAN_W-1:0]     mean_mag;
  logic signed [15:0]               rd_sample;
  logic signed [15:0]               rd_gain;
  logic signed [15:0]               rd_offset;
  logic signed [lnorm_pkg::MEAN_W-1:0] dev;
  logic signed [2*lnorm_pkg::MEAN_W-1:0] dev_sq;
  logic signed [lnorm_pkg::P_W-1:0] p_rnd;
  logic signed [lnorm_pkg::P_W-lnorm_pkg::Q_FRAC-1:0] y_sh;
  logic signed [lnorm_pkg::P_W-lnorm_pkg::Q_FRAC:0] y_sum;
  logic signed [15:0]               y_sat;

  assign full    = count_q == CW'(MAX_LEN);
  assign n7      = lnorm_pkg::N_W'(count_q);
  assign num     = $signed({sum_q[lnorm_pkg::SUM_W-1], sum_q, 1'b0})
                 + $signed({{(lnorm_pkg::NUM_W - lnorm_pkg::N_W){1'b0}}, n7});
  assign num_neg = num[lnorm_pkg::NUM_W-1];
  assign num_abs = num_neg ? lnorm_pkg::NUM_W'(-num) : lnorm_pkg::NUM_W'(num);

  always_comb begin
    case (cmd_i.div_sel)
      lnorm_pkg::DIV_MEAN: begin
        div_dividend = lnorm_pkg::DIVN_W'(num_abs);
        div_divisor  = lnorm_pkg::DIVD_W'({n7, 1'b0});
      end
      lnorm_pkg::DIV_VAR: begin
        div_dividend = lnorm_pkg::DIVN_W'(sq_q);
        div_divisor  = lnorm_pkg::DIVD_W'(n7);
      end
      lnorm_pkg::DIV_INV: begin
        div_dividend = {1'b1, {(lnorm_pkg::DIVN_W - 1){1'b0}}};
        div_divisor  = vq_q;
      end
      default: begin
        div_dividend = '0;
        div_divisor  = '0;
      end
    endcase
  end

  lnorm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  lnorm_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .rad_i   (div_quot),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  // floor division: round the magnitude up only for a negative numerator
  assign mean_mag  = div_quot[lnorm_pkg::MEAN_W-1:0]
                   + lnorm_pkg::MEAN_W'(num_neg && (div_rem != '0));
  assign rd_sample = rd_q[15:0];
  assign rd_gain   = rd_q[31:16];
  assign rd_offset = rd_q[47:32];
  assign dev       = $signed({rd_sample[15], rd_sample}) - mean_q;
  assign dev_sq    = dev * dev;
  assign p_rnd     = p_q + (lnorm_pkg::P_W'(1) <<< (lnorm_pkg::Q_FRAC - 1));
  assign y_sh      = p_rnd[lnorm_pkg::P_W-1:lnorm_pkg::Q_FRAC];
  assign y_sum     = $signed({y_sh[lnorm_pkg::P_W-lnorm_pkg::Q_FRAC-1], y_sh})
                   + (lnorm_pkg::P_W-lnorm_pkg::Q_FRAC+1)'(ofs_q);

  always_comb begin
    if (y_sum > 32767) begin
      y_sat = 16'sh7fff;
    end else if (y_sum < -32768) begin
      y_sat = 16'sh8000;
    end else begin
      y_sat = y_sum[15:0];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q       <= lnorm_pkg::EPS_RESET;
      count_q     <= '0;
      sum_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        eps_q <= cfg_wdata_i;
      end
      if (cmd_i.vec_clr) begin
        count_q <= '0;
        sum_q   <= '0;
        ovf_q   <= 1'b0;
      end else if (cmd_i.load) begin
        if (full) begin
          ovf_q <= 1'b1;
        end else begin
          count_q <= count_q + 1'b1;
          sum_q   <= sum_q + lnorm_pkg::SUM_W'(sample_i);
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // element store
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !full) begin
      mem[count_q[AW-1:0]] <= {offset_i, gain_i, sample_i};
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[addr_q];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.addr_clr) begin
      addr_q <= '0;
    end else if (cmd_i.addr_inc) begin
      addr_q <= addr_q + 1'b1;
    end
    if (cmd_i.mean_take) begin
      mean_q <= num_neg ? -$signed(mean_mag) : $signed(mean_mag);
    end
    if (cmd_i.sq_mul) begin
      dsq_q <= dev_sq[lnorm_pkg::DSQ_W-1:0];
    end
    if (cmd_i.sq_clr) begin
      sq_q <= '0;
    end else if (cmd_i.sq_acc) begin
      sq_q <= sq_q + lnorm_pkg::SQ_W'(dsq_q);
    end
    if (cmd_i.var_take) begin
      vq_q <= div_quot[lnorm_pkg::DIVD_W-1:0] + lnorm_pkg::DIVD_W'(eps_q);
    end
    if (cmd_i.inv_cap) begin
      inv_q <= lnorm_pkg::INV_CAP;
    end else if (cmd_i.sqrt_take) begin
      inv_q <= (sqrt_root > lnorm_pkg::INV_CAP) ? lnorm_pkg::INV_CAP : sqrt_root;
    end
    if (cmd_i.m1) begin
      gd_q  <= rd_gain * dev;
      ofs_q <= rd_offset;
    end
    if (cmd_i.m2) begin
      p_q <= gd_q * $signed({1'b0, inv_q});
    end
    if (cmd_i.out_load) begin
      norm_q  <= y_sat;
      last_q  <= sts_o.addr_last;
      oflag_q <= ovf_q;
    end
  end

  assign sts_o.div_done  = div_done;
  assign sts_o.sqrt_done = sqrt_done;
  assign sts_o.addr_last = (CW'(addr_q) + 1'b1) == count_q;
  assign sts_o.vq_zero   = vq_q == '0;
  assign sts_o.out_busy  = out_valid_q;

  assign out_valid_o  = out_valid_q;
  assign normalized_o = norm_q;
  assign last_out_o   = last_q;
  assign overflow_o   = oflag_q;

endmodule
`default_nettype wire

### hdl/lnorm_ctrl.sv
// lnorm_ctrl: sequencer for load, mean, variance, inverse root and emit passes
// depends on lnorm_pkg
`default_nettype none
module lnorm_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             in_last_i,
  output logic                  in_ready_o,
  output lnorm_pkg::cmd_t       cmd_o,
  input  wire lnorm_pkg::sts_t  sts_i
);

  lnorm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lnorm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.div_sel = lnorm_pkg::DIV_MEAN;
    in_ready_o    = 1'b0;
    case (state_q)
      lnorm_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            state_d = lnorm_pkg::ST_MEAN_ST;
          end
        end
      end
      lnorm_pkg::ST_MEAN_ST: begin
        cmd_o.div_start = 1'b1;
        state_d         = lnorm_pkg::ST_MEAN_RUN;
      end
      lnorm_pkg::ST_MEAN_RUN: begin
        if (sts_i.div_done) begin
          cmd_o.mean_take = 1'b1;
          cmd_o.addr_clr  = 1'b1;
          cmd_o.sq_clr    = 1'b1;
          state_d         = lnorm_pkg::ST_VAR_RD;
        end
      end
      lnorm_pkg::ST_VAR_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = lnorm_pkg::ST_VAR_MUL;
      end
      lnorm_pkg::ST_VAR_MUL: begin
        cmd_o.sq_mul = 1'b1;
        state_d      = lnorm_pkg::ST_VAR_ACC;
      end
      lnorm_pkg::ST_VAR_ACC: begin
        cmd_o.sq_acc = 1'b1;
        if (sts_i.addr_last) begin
          cmd_o.addr_clr = 1'b1;
          state_d        = lnorm_pkg::ST_VDIV_ST;
        end else begin
          cmd_o.addr_inc = 1'b1;
          state_d        = lnorm_pkg::ST_VAR_RD;
        end
      end
      lnorm_pkg::ST_VDIV_ST: begin
        cmd_o.div_sel   = lnorm_pkg::DIV_VAR;
        cmd_o.div_start = 1'b1;
        state_d         = lnorm_pkg::ST_VDIV_RUN;
      end
      lnorm_pkg::ST_VDIV_RUN: begin
        cmd_o.div_sel = lnorm_pkg::DIV_VAR;
        if (sts_i.div_done) begin
          cmd_o.var_take = 1'b1;
          state_d        = lnorm_pkg::ST_IDIV_ST;
        end
      end
      lnorm_pkg::ST_IDIV_ST: begin
        cmd_o.div_sel = lnorm_pkg::DIV_INV;
        if (sts_i.vq_zero) begin
          cmd_o.inv_cap = 1'b1;
          state_d       = lnorm_pkg::ST_EMIT_RD;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = lnorm_pkg::ST_IDIV_RUN;
        end
      end
      lnorm_pkg::ST_IDIV_RUN: begin
        cmd_o.div_sel = lnorm_pkg::DIV_INV;
        if (sts_i.div_done) begin
          state_d = lnorm_pkg::ST_SQRT_ST;
        end
      end
      lnorm_pkg::ST_SQRT_ST: begin
        cmd_o.sqrt_start = 1'b1;
        state_d          = lnorm_pkg::ST_SQRT_RUN;
      end
      lnorm_pkg::ST_SQRT_RUN: begin
        if (sts_i.sqrt_done) begin
          cmd_o.sqrt_take = 1'b1;
          state_d         = lnorm_pkg::ST_EMIT_RD;
        end
      end
      lnorm_pkg::ST_EMIT_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = lnorm_pkg::ST_EMIT_M1;
      end
      lnorm_pkg::ST_EMIT_M1: begin
        cmd_o.m1 = 1'b1;
        state_d  = lnorm_pkg::ST_EMIT_M2;
      end
      lnorm_pkg::ST_EMIT_M2: begin
        cmd_o.m2 = 1'b1;
        state_d  = lnorm_pkg::ST_EMIT_OUT;
      end
      lnorm_pkg::ST_EMIT_OUT: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          if (sts_i.addr_last) begin
            cmd_o.vec_clr = 1'b1;
            state_d       = lnorm_pkg::ST_IDLE;
          end else begin
            cmd_o.addr_inc = 1'b1;
            state_d        = lnorm_pkg::ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = lnorm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### hdl/layer_normalization.sv
// layer_normalization: one item per cycle while loading; on the last-marked item the
// mean divide, a read, multiply and accumulate pass for the variance, the variance divide,
// the inverse divide and the root run follow (the last two skipped for a zero variance),
// then each result is read, multiplied twice and loaded once the output is free; the next
// vector waits for the last result; async active-low reset clears counters, flags, state
// depends on lnorm_pkg, lnorm_if, lnorm_ctrl, lnorm_dp
`default_nettype none
module layer_normalization #(
  parameter int unsigned MAX_LEN = 64
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  lnorm_in_if.sink          in_i,
  lnorm_out_if.source       out_o,
  input  wire logic         cfg_we_i,
  input  wire logic [15:0]  cfg_wdata_i
);

  lnorm_pkg::cmd_t cmd;
  lnorm_pkg::sts_t sts;
  logic            in_ready;

  assign in_i.ready = in_ready;

  lnorm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_last_i  (in_i.last_in),
    .in_ready_o (in_ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  lnorm_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .sample_i     (in_i.sample),
    .gain_i       (in_i.gain),
    .offset_i     (in_i.offset),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .normalized_o (out_o.normalized),
    .last_out_o   (out_o.last_out),
    .overflow_o   (out_o.overflow)
  );

endmodule
`default_nettype wire

### tb/layer_normalization_test_if.sv
`timescale 1ns / 1ps
// channel interfaces for the layer normalization testbench
// reuses lnorm_in_if and lnorm_out_if from the rtl, nothing of its own here
`default_nettype none
`default_nettype wire

### tb/layer_normalization_test.sv
`timescale 1ns / 1ps
// testbench for layer_normalization: directed and random vectors against a fixed-point predictor
// depends on lnorm_pkg, lnorm_if and the layer_normalization rtl
`default_nettype none
module layer_normalization_test;

  localparam int MAX_VEC = 64;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic signed [15:0] normalized;
    logic               last_out;
    logic               overflow;
  } norm_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  lnorm_in_if  in_ch ();
  lnorm_out_if out_ch ();

  layer_normalization #(.MAX_LEN(MAX_VEC)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state
  logic signed [15:0] vec_sample[MAX_VEC];
  logic signed [15:0] vec_gain[MAX_VEC];
  logic signed [15:0] vec_offset[MAX_VEC];
  int unsigned vec_count;
  longint vec_sum;
  bit vec_dropped;
  logic [15:0] epsilon;
  norm_result_t expected_q[$];

  int errors = 0;
  int sent_items = 0;
  int got_results = 0;
  int vectors_done = 0;
  longint cycles = 0;
  bit hold_off = 1'b0;
  int gap_max = 3;
  int stall_pct = 25;

  function automatic longint unsigned int_sqrt(longint unsigned q);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > q) b >>= 2;
    while (b != 0) begin
      if (q >= r + b) begin
        q -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint floor_div(longint a, longint b);
    if (a >= 0) return a / b;
    return -((-a + b - 1) / b);
  endfunction

  task automatic normalize_vector();
    longint mu, dv, p, y;
    longint unsigned sq, vq, inv;
    int n;
    norm_result_t r;
    n = vec_count;
    mu = floor_div(2 * vec_sum + n, 2 * n);
    sq = 0;
    for (int e = 0; e < n; e++) begin
      dv = longint'(vec_sample[e]) - mu;
      sq += longint'(dv * dv);
    end
    vq = sq / n + epsilon;
    if (vq == 0) inv = 64'd1 << 28;
    else begin
      inv = int_sqrt((64'd1 << 56) / vq);
      if (inv > (64'd1 << 28)) inv = 64'd1 << 28;
    end
    for (int e = 0; e < n; e++) begin
      dv = longint'(vec_sample[e]) - mu;
      p = longint'(vec_gain[e]) * dv * longint'(inv) + (64'sd1 << 27);
      y = (p >>> 28) + longint'(vec_offset[e]);
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      r.normalized = y[15:0];
      r.last_out = (e == n - 1);
      r.overflow = vec_dropped;
      expected_q.push_back(r);
    end
    vec_count = 0;
    vec_sum = 0;
    vec_dropped = 1'b0;
    vectors_done++;
  endtask

  task automatic predict_element(logic signed [15:0] s, logic signed [15:0] g,
                                 logic signed [15:0] o, logic lst);
    if (vec_count < MAX_VEC) begin
      vec_sample[vec_count] = s;
      vec_gain[vec_count] = g;
      vec_offset[vec_count] = o;
      vec_count++;
      vec_sum += s;
    end else begin
      vec_dropped = 1'b1;
    end
    if (lst && vec_count != 0) normalize_vector();
  endtask

  task automatic send_element(logic signed [15:0] s, logic signed [15:0] g,
                              logic signed [15:0] o, logic lst);
    in_ch.valid <= 1'b1;
    in_ch.sample <= s;
    in_ch.gain <= g;
    in_ch.offset <= o;
    in_ch.last_in <= lst;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_element(s, g, o, lst);
    sent_items++;
    @(negedge clk_i);
    if ($urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(negedge clk_i);
    end
  endtask

  task automatic idle_sender();
    in_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    idle_sender();
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_epsilon(logic [15:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    epsilon = v;
  endtask

  function automatic logic signed [15:0] rand_q();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'(signed'($urandom_range(0, 8191)) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_vector(int len, bit big_vals);
    logic signed [15:0] s;
    for (int i = 0; i < len; i++) begin
      s = big_vals ? rand_q() : 16'(signed'($urandom_range(0, 16383)) - 8192);
      send_element(s, rand_q(), rand_q(), i == len - 1);
    end
  endtask

  task automatic test_directed();
    send_element(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1);
    send_element(16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
    send_element(16'sh7fff, 16'sh7fff, 16'sh8000, 1'b1);
    send_element(16'sh0000, 16'sh1000, 16'sh0000, 1'b0);
    send_element(16'sh0000, 16'sh1000, 16'sh0000, 1'b1);
    send_element(16'sh5555, 16'shaaaa, 16'sh5555, 1'b0);
    send_element(16'shaaaa, 16'sh5555, 16'shaaaa, 1'b0);
    send_element(16'sh0001, 16'shffff, 16'sh0000, 1'b1);
    drain();
  endtask

  task automatic test_zero_epsilon();
    write_epsilon(16'd0);
    // zero variance, inverse root saturates
    send_element(16'sh0123, 16'sh1000, 16'sh0010, 1'b0);
    send_element(16'sh0123, 16'sh7fff, 16'sh8000, 1'b1);
    send_vector(5, 1'b1);
    drain();
    write_epsilon(16'hffff);
    send_vector(4, 1'b0);
    send_vector(3, 1'b1);
    drain();
  endtask

  task automatic test_overflow();
    write_epsilon(16'd168);
    send_vector(MAX_VEC, 1'b1);
    // drops including the last-marked one
    send_vector(MAX_VEC + 5, 1'b0);
    drain();
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    send_vector(6, 1'b0);
    send_vector(20, 1'b1);
    hold_off = 1'b0;
    drain();
  endtask

  task automatic test_random();
    int len;
    for (int ph = 0; ph < 3; ph++) begin
      write_epsilon(ph == 0 ? 16'd168 : 16'($urandom));
      gap_max = (ph == 2) ? 1 : 6;
      stall_pct = (ph == 2) ? 0 : 40;
      for (int k = 0; k < 3; k++) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 64) : $urandom_range(1, 8);
        send_vector(len, $urandom_range(0, 1));
      end
      drain();
    end
  endtask

  // receiver
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(negedge clk_i);
        hold_off = 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    norm_result_t exp_r;
    cycles <= cycles + 1;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got_results++;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: %0d", out_ch.normalized);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (exp_r.normalized !== out_ch.normalized) begin
          $error("normalized: expected %0d, actual %0d", exp_r.normalized,
                 out_ch.normalized);
          errors++;
        end
        if (exp_r.last_out !== out_ch.last_out) begin
          $error("last_out: expected %0d, actual %0d", exp_r.last_out, out_ch.last_out);
          errors++;
        end
        if (exp_r.overflow !== out_ch.overflow) begin
          $error("overflow: expected %0d, actual %0d", exp_r.overflow, out_ch.overflow);
          errors++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    in_ch.gain = '0;
    in_ch.offset = '0;
    in_ch.last_in = 1'b0;
    vec_count = 0;
    vec_sum = 0;
    vec_dropped = 1'b0;
    epsilon = lnorm_pkg::EPS_RESET;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_zero_epsilon();
    test_overflow();
    test_backpressure();
    test_random();
    drain();
    $display("sent %0d items over %0d vectors, checked %0d results", sent_items,
             vectors_done, got_results);
    $display("covered epsilon extremes, overflowing vectors and a long output stall");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire

### sim.f
hdl/lnorm_pkg.sv
hdl/lnorm_if.sv
hdl/lnorm_div.sv
hdl/lnorm_isqrt.sv
hdl/lnorm_dp.sv
hdl/lnorm_ctrl.sv
hdl/layer_normalization.sv
tb/layer_normalization_test_if.sv
tb/layer_normalization_test.sv
